FILE: design/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types and constants for the playback position history block.
// ----------------------------------------------------------------------------
package pph_pkg;

  localparam int unsigned HistoryDepth = 8;
  localparam int unsigned IdxW         = $clog2(HistoryDepth);
  localparam int unsigned FieldW       = 48;
  localparam int unsigned ModeW        = 2;

  typedef logic [FieldW-1:0] field_t;
  typedef logic [IdxW-1:0]   idx_t;

  typedef enum logic [ModeW-1:0] {
    MODE_RESET  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ADD,
    ST_CLAMP
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic hist_clear;
    logic hist_append;
    logic hist_update;
    logic search_init;
    logic search_step;
    logic sum_load;
    logic result_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic at_oldest;
  } status_t;

endpackage

FILE: design/pph_ctrl.sv
// ----------------------------------------------------------------------------
// pph_ctrl
// Controller: accepts transactions and sequences the query search.
// ----------------------------------------------------------------------------
module pph_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [pph_pkg::ModeW-1:0] mode_i,
  input  pph_pkg::status_t        status_i,
  output pph_pkg::cmd_t           cmd_o,
  output logic                    busy_o
);
  import pph_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && (mode_e'(mode_i) == MODE_QUERY)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.hit || status_i.at_oldest) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          case (mode_e'(mode_i))
            MODE_RESET:  cmd_o.hist_clear  = 1'b1;
            MODE_APPEND: cmd_o.hist_append = 1'b1;
            MODE_UPDATE: cmd_o.hist_update = 1'b1;
            MODE_QUERY:  cmd_o.search_init = 1'b1;
            default:     cmd_o             = '0;
          endcase
        end
      end
      ST_SEARCH: cmd_o.search_step = 1'b1;
      ST_ADD:    cmd_o.sum_load    = 1'b1;
      ST_CLAMP:  cmd_o.result_load = 1'b1;
      default:   cmd_o             = '0;
    endcase
  end

endmodule

FILE: design/pph_datapath.sv
// ----------------------------------------------------------------------------
// pph_datapath
// History registers, serial search, saturating add and clamp.
// ----------------------------------------------------------------------------
module pph_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pph_pkg::cmd_t       cmd_i,
  input  pph_pkg::field_t     samples_written_i,
  input  pph_pkg::field_t     segment_start_i,
  input  pph_pkg::field_t     segment_end_i,
  input  pph_pkg::field_t     device_position_i,
  output pph_pkg::status_t    status_o,
  output logic                done_o,
  output pph_pkg::field_t     file_position_o,
  output logic                too_old_o
);
  import pph_pkg::*;

  localparam idx_t Top = idx_t'(HistoryDepth - 1);

  field_t count_q [HistoryDepth];
  field_t start_q [HistoryDepth];
  field_t end_q   [HistoryDepth];

  idx_t   idx_q;
  field_t dev_q;
  field_t delta_q;
  field_t sel_start_q;
  field_t sel_end_q;
  logic   old_q;
  field_t pos_q;

  logic            done_q;
  field_t          file_pos_q;
  logic            too_old_q;

  logic [FieldW:0] app_sum;
  logic [FieldW:0] pos_sum;
  field_t          cur_count;
  logic            cur_hit;

  assign app_sum   = {1'b0, count_q[Top]} + {1'b0, samples_written_i};
  assign cur_count = count_q[idx_q];
  assign cur_hit   = (cur_count <= dev_q);
  assign pos_sum   = {1'b0, sel_start_q} + {1'b0, delta_q};

  assign status_o.hit       = cur_hit;
  assign status_o.at_oldest = (idx_q == '0);

  // history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistoryDepth; i++) begin
        count_q[i] <= '0;
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
    end else if (cmd_i.hist_clear) begin
      for (int i = 0; i < HistoryDepth; i++) begin
        count_q[i] <= '0;
      end
      for (int i = 0; i < HistoryDepth - 1; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
      start_q[Top] <= segment_start_i;
      end_q[Top]   <= segment_end_i;
    end else if (cmd_i.hist_append) begin
      for (int i = 0; i < HistoryDepth - 1; i++) begin
        count_q[i] <= count_q[i+1];
        start_q[i] <= start_q[i+1];
        end_q[i]   <= end_q[i+1];
      end
      count_q[Top] <= app_sum[FieldW] ? '1 : app_sum[FieldW-1:0];
      start_q[Top] <= segment_start_i;
      end_q[Top]   <= segment_end_i;
    end else if (cmd_i.hist_update) begin
      start_q[Top] <= segment_start_i;
      end_q[Top]   <= segment_end_i;
    end
  end

  // search and result path
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_init) begin
      idx_q <= Top;
      dev_q <= device_position_i;
    end else if (cmd_i.search_step) begin
      if (cur_hit || (idx_q == '0)) begin
        delta_q     <= cur_hit ? (dev_q - cur_count) : '0;
        old_q       <= !cur_hit;
        sel_start_q <= start_q[idx_q];
        sel_end_q   <= end_q[idx_q];
      end else begin
        idx_q <= idx_q - idx_t'(1);
      end
    end
    if (cmd_i.sum_load) begin
      pos_q <= pos_sum[FieldW] ? '1 : pos_sum[FieldW-1:0];
    end
    if (cmd_i.result_load) begin
      file_pos_q <= (pos_q > sel_end_q) ? sel_end_q : pos_q;
      too_old_q  <= old_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.result_load;
    end
  end

  assign done_o          = done_q;
  assign file_position_o = file_pos_q;
  assign too_old_o       = too_old_q;

endmodule

FILE: design/playback_position_history.sv
// ----------------------------------------------------------------------------
// playback_position_history
// Short history of playback segments mapping device positions to file positions.
// ----------------------------------------------------------------------------
// reset, append and update transactions are applied from idle; busy stays low
// a query holds busy through the scan of the history entries from newest to oldest,
// then through the saturating add and the clamp
// done_o pulses for one cycle after the clamp; the receiver cannot stall
// rst_ni clears the whole history to zero and returns the controller to idle
module playback_position_history (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [pph_pkg::ModeW-1:0]  mode_i,
  input  logic [pph_pkg::FieldW-1:0] samples_written_i,
  input  logic [pph_pkg::FieldW-1:0] segment_start_i,
  input  logic [pph_pkg::FieldW-1:0] segment_end_i,
  input  logic [pph_pkg::FieldW-1:0] device_position_i,
  output logic                      done_o,
  output logic [pph_pkg::FieldW-1:0] file_position_o,
  output logic                      too_old_o
);
  import pph_pkg::*;

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t status;

  // controller: idle accepts a transaction, query walks search/add/clamp
  pph_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // datapath: history registers plus the query arithmetic
  pph_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .samples_written_i (samples_written_i),
    .segment_start_i   (segment_start_i),
    .segment_end_i     (segment_end_i),
    .device_position_i (device_position_i),
    .status_o          (status),
    .done_o            (done_o),
    .file_position_o   (file_position_o),
    .too_old_o         (too_old_o)
  );

endmodule

FILE: design/pph_checker.sv
// ----------------------------------------------------------------------------
// pph_checker
// Port-level checks on transaction acceptance and result strobes.
// ----------------------------------------------------------------------------
module pph_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [pph_pkg::ModeW-1:0] mode_i,
  input logic                      done_o
);
  import pph_pkg::*;

  // a query holds the block busy right after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i == MODE_QUERY)) |=> busy)
    else $error("query did not raise busy");

  // other transactions complete at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i != MODE_QUERY)) |=> !busy)
    else $error("non-query transaction held the block busy");

  // results never come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back to back result strobes");

  // a result ends a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe outside end of query");

endmodule

bind playback_position_history pph_checker u_pph_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .mode_i (mode_i),
  .done_o (done_o)
);

FILE: dv/playback_position_history_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playback_position_history_checker
// Watches the command and result channels of the position history, keeps its
// own copy of the segment history and compares every mapped position against
// the value predicted when the query was accepted.
// ----------------------------------------------------------------------------
module playback_position_history_checker
  import pph_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  logic   busy_i,
  input  mode_e  mode_i,
  input  field_t samples_written_i,
  input  field_t segment_start_i,
  input  field_t segment_end_i,
  input  field_t device_position_i,
  input  logic   done_i,
  input  field_t file_position_i,
  input  logic   too_old_i,
  output int     mismatches_o,
  output int     pending_o
);

  localparam field_t FieldMax = '1;
  localparam int     Newest   = HistoryDepth - 1;

  typedef struct packed {
    field_t file_position;
    logic   too_old;
  } mapping_t;

  field_t   seg_count [HistoryDepth];
  field_t   seg_start [HistoryDepth];
  field_t   seg_end   [HistoryDepth];
  mapping_t mapping_q [$];

  function automatic field_t sat_sum(field_t a, field_t b);
    logic [FieldW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FieldW] ? FieldMax : s[FieldW-1:0];
  endfunction

  // newest to oldest, first entry whose count does not exceed the position
  function automatic mapping_t map_position(field_t dev);
    mapping_t m;
    int       hit;
    int       i;
    field_t   offset;
    field_t   pos;
    hit    = -1;
    offset = '0;
    for (i = Newest; i >= 0; i--) begin
      if (hit < 0 && seg_count[i] <= dev) begin
        hit    = i;
        offset = dev - seg_count[i];
      end
    end
    m.too_old = (hit < 0);
    if (hit < 0) hit = 0;
    pos = sat_sum(seg_start[hit], offset);
    m.file_position = (pos > seg_end[hit]) ? seg_end[hit] : pos;
    return m;
  endfunction

  task automatic clear_history();
    int i;
    for (i = 0; i < HistoryDepth; i++) begin
      seg_count[i] = '0;
      seg_start[i] = '0;
      seg_end[i]   = '0;
    end
  endtask

  task automatic apply_command(mode_e m, field_t written, field_t lo, field_t hi,
                               field_t dev);
    field_t prev;
    int     i;
    case (m)
      MODE_RESET: begin
        clear_history();
        seg_start[Newest] = lo;
        seg_end[Newest]   = hi;
      end
      MODE_APPEND: begin
        prev = seg_count[Newest];
        for (i = 0; i < Newest; i++) begin
          seg_count[i] = seg_count[i+1];
          seg_start[i] = seg_start[i+1];
          seg_end[i]   = seg_end[i+1];
        end
        seg_count[Newest] = sat_sum(prev, written);
        seg_start[Newest] = lo;
        seg_end[Newest]   = hi;
      end
      MODE_UPDATE: begin
        seg_start[Newest] = lo;
        seg_end[Newest]   = hi;
      end
      default: mapping_q.push_back(map_position(dev));
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mapping_t want;
    if (!rst_ni) begin
      clear_history();
      mapping_q.delete();
      mismatches_o = 0;
    end else begin
      // a result can share an edge with the next command, so check it first
      if (done_i) begin
        if (mapping_q.size() == 0) begin
          $error("result with no query pending: file_position %0h too_old %0b",
                 file_position_i, too_old_i);
          mismatches_o++;
        end else begin
          want = mapping_q.pop_front();
          if (file_position_i !== want.file_position) begin
            $error("file_position: expected %0h, actual %0h",
                   want.file_position, file_position_i);
            mismatches_o++;
          end
          if (too_old_i !== want.too_old) begin
            $error("too_old: expected %0b, actual %0b", want.too_old, too_old_i);
            mismatches_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_command(mode_i, samples_written_i, segment_start_i, segment_end_i,
                      device_position_i);
      end
    end
    pending_o = mapping_q.size();
  end

endmodule

FILE: dv/tb_playback_position_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playback_position_history
// Drives reset, append, update and query transactions into the position
// history: a directed opening on the boundary cases, then random traffic with
// the sender idling at several rates. A checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_playback_position_history;
  import pph_pkg::*;

  localparam int     IdleLimit = 2000;  // cycles with no transaction at all
  localparam int     NumRandom = 800;
  localparam field_t FieldMax  = '1;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  mode_e  mode;
  field_t samples_written;
  field_t segment_start;
  field_t segment_end;
  field_t device_position;
  logic   done_o;
  field_t file_position;
  logic   too_old;
  int     mismatches;
  int     pending;

  // rough view of the newest write count, only used to aim queries at the history
  field_t tail_count;
  // chance in percent that the sender idles after a transaction
  int     idle_pct;
  int     idle_cycles;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  playback_position_history i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .mode_i            (mode),
    .samples_written_i (samples_written),
    .segment_start_i   (segment_start),
    .segment_end_i     (segment_end),
    .device_position_i (device_position),
    .done_o            (done_o),
    .file_position_o   (file_position),
    .too_old_o         (too_old)
  );

  playback_position_history_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .mode_i            (mode),
    .samples_written_i (samples_written),
    .segment_start_i   (segment_start),
    .segment_end_i     (segment_end),
    .device_position_i (device_position),
    .done_i            (done_o),
    .file_position_i   (file_position),
    .too_old_i         (too_old),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  function automatic field_t rand_field();
    return {16'($urandom()), $urandom()};
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(mode_e m, field_t written, field_t lo, field_t hi, field_t dev);
    start           <= 1'b1;
    mode            <= m;
    samples_written <= written;
    segment_start   <= lo;
    segment_end     <= hi;
    device_position <= dev;
    if (m == MODE_RESET) begin
      tail_count = '0;
    end else if (m == MODE_APPEND) begin
      tail_count = (tail_count > FieldMax - written) ? FieldMax : tail_count + written;
    end
    // busy is stable mid-cycle and is what the block sees at the next edge
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic maybe_pause();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // mostly well-formed segments and queries into the live history, some raw noise
  task automatic random_item();
    mode_e  m;
    field_t w;
    field_t lo;
    field_t hi;
    field_t dev;
    field_t back;
    int     pick;
    w    = rand_field();
    lo   = rand_field();
    hi   = rand_field();
    dev  = rand_field();
    pick = $urandom_range(0, 99);
    if (pick < 6)       m = MODE_RESET;
    else if (pick < 40) m = MODE_APPEND;
    else if (pick < 50) m = MODE_UPDATE;
    else                m = MODE_QUERY;
    // segment span: short and ordered most of the time
    pick = $urandom_range(0, 9);
    if (pick < 7)       hi = lo + field_t'($urandom_range(0, 5000));
    else if (pick == 7) hi = FieldMax;
    // write counts: small steps, now and then a saturating jump
    pick = $urandom_range(0, 19);
    if (pick < 17)       w = field_t'($urandom_range(0, 3000));
    else if (pick == 17) w = FieldMax;
    // device position: reach back over a few segments, past the oldest at times
    pick = $urandom_range(0, 19);
    back = field_t'($urandom_range(0, 20000));
    if (pick < 14)      dev = (tail_count > back) ? tail_count - back : '0;
    else if (pick < 17) dev = tail_count + field_t'($urandom_range(0, 50));
    else if (pick == 17) dev = FieldMax;
    issue(m, w, lo, hi, dev);
  endtask

  // watchdog: nothing accepted on either channel for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_pct [3];
    int p;
    int n;
    int k;
    phase_pct       = '{0, 47, 24};
    rst_ni          = 1'b0;
    start           = 1'b0;
    mode            = MODE_RESET;
    samples_written = '0;
    segment_start   = '0;
    segment_end     = '0;
    device_position = '0;
    tail_count      = '0;
    idle_pct        = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // queries on the cleared history, lowest and highest position
    issue(MODE_QUERY, rand_field(), rand_field(), rand_field(), '0);
    issue(MODE_QUERY, rand_field(), rand_field(), rand_field(), FieldMax);
    // history reset to an all-ones segment, the add saturates
    issue(MODE_RESET, FieldMax, FieldMax, FieldMax, FieldMax);
    issue(MODE_QUERY, '0, '0, '0, FieldMax);
    // newest rewritten, query lands inside it
    issue(MODE_UPDATE, rand_field(), '0, FieldMax, rand_field());
    issue(MODE_QUERY, '0, '0, '0, 48'd12345);
    // three appends with tight ends so that some queries clamp
    issue(MODE_APPEND, 48'd100, 48'd1000, 48'd1010, rand_field());
    issue(MODE_APPEND, 48'd50, 48'd5000, 48'd5500, rand_field());
    issue(MODE_APPEND, 48'd10, 48'd7000, 48'd7005, rand_field());
    issue(MODE_QUERY, '0, '0, '0, 48'd120);
    issue(MODE_QUERY, '0, '0, '0, 48'd155);
    issue(MODE_QUERY, '0, '0, '0, 48'd170);
    // fill the whole history so the oldest count is above zero
    for (k = 0; k < HistoryDepth; k++) begin
      issue(MODE_APPEND, 48'd1000, field_t'(k * 100), field_t'(k * 100 + 50), rand_field());
    end
    // position older than every entry, lowest position too
    issue(MODE_QUERY, '0, '0, '0, 48'd5);
    issue(MODE_QUERY, FieldMax, FieldMax, FieldMax, '0);
    // count saturates on a huge append
    issue(MODE_APPEND, FieldMax, 48'd42, FieldMax, '0);
    issue(MODE_QUERY, '0, '0, '0, FieldMax);

    // random traffic, one phase per sender idle rate
    for (p = 0; p < 3; p++) begin
      idle_pct = phase_pct[p];
      for (n = 0; n < NumRandom / 3; n++) begin
        random_item();
        maybe_pause();
      end
    end
    start <= 1'b0;

    // drain: every query answered, then a wait for stray results
    wait (pending == 0);
    repeat (HistoryDepth + 4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pph_pkg.sv
design/pph_ctrl.sv
design/pph_datapath.sv
design/playback_position_history.sv
design/pph_checker.sv
dv/playback_position_history_checker.sv
dv/tb_playback_position_history.sv
